### hw/rtl/tle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, types and codes of the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_BYTES    = 64;
    localparam int HISTORY_DEPTH = 8;

    localparam int CNT_W  = $clog2(LINE_BYTES);
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int HIST_WORDS = HISTORY_DEPTH * LINE_BYTES;
    localparam int HADDR_W = $clog2(HIST_WORDS);

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_BSL  = 8'h5C;

    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_SHOW  = 2'd1;
    localparam logic [1:0] RD_CLEAR = 2'd2;

    localparam logic [1:0] REG_ECHO = 2'd0;
    localparam logic [1:0] REG_UP   = 2'd1;
    localparam logic [1:0] REG_DOWN = 2'd2;

    typedef struct packed {
        logic       echo_en;
        logic [7:0] up_code;
        logic [7:0] dn_code;
    } t_cfg;

    typedef struct packed {
        logic       op_valid;
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [5:0] read_index;
        logic       push_history;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [5:0] line_length;
        logic       overflow;
        logic       line_ready;
        logic [1:0] redraw;
        logic       erase_echo;
        logic [7:0] echo_byte;
        logic       echo_valid;
    } t_result;

endpackage
`default_nettype wire

### hw/rtl/terminal_line_editor_with_history.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a received byte, read or release passes the sequencer states EXEC
// and EMIT and then the result register; a history recall or push also runs
// the byte-wide copy between line memory and history memory in COPY or PUSH.
// One item at a time: no new item is taken until the sequencer has handed
// the last result to the result register.
// Reset: synchronous, active low; line and history empty, registers to defaults.
// ----------------------------------------------------------------------------
// terminal_line_editor_with_history
// Top level: stream ports, configuration registers, result register and memories.
// ----------------------------------------------------------------------------
module terminal_line_editor_with_history (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] data_byte, [13:8] read_index, [14] push_history, [15] zero
    input  wire  [15:0] i_s_axis_tdata,
    // [1:0] opcode
    input  wire  [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [0] echo_valid, [8:1] echo_byte, [9] erase_echo, [11:10] redraw,
    // [12] line_ready, [13] overflow, [19:14] line_length, [27:20] read_data
    output logic [31:0] o_m_axis_tdata
);
    tle_pkg::t_cfg    r_cfg;
    tle_pkg::t_item   item;
    tle_pkg::t_result result;
    logic             emit_valid;
    logic             emit_ready;
    logic             r_out_valid;
    logic [27:0]      r_out_data;

    logic                        line_we, hist_we;
    logic [tle_pkg::CNT_W-1:0]   line_waddr, line_raddr;
    logic [7:0]                  line_wdata, line_rdata, hist_wdata, hist_rdata;
    logic [tle_pkg::HADDR_W-1:0] hist_waddr, hist_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_en <= 1'b1;
            r_cfg.up_code <= 8'd65;
            r_cfg.dn_code <= 8'd66;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tle_pkg::REG_ECHO: r_cfg.echo_en <= i_cfg_wdata[0];
                tle_pkg::REG_UP:   r_cfg.up_code <= i_cfg_wdata;
                tle_pkg::REG_DOWN: r_cfg.dn_code <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.op_valid     = i_s_axis_tvalid;
        item.opcode       = i_s_axis_tuser;
        item.data_byte    = i_s_axis_tdata[7:0];
        item.read_index   = i_s_axis_tdata[13:8];
        item.push_history = i_s_axis_tdata[14];
    end

    // The result register frees the sequencer while the result waits downstream.
    assign emit_ready      = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_ready) begin
            r_out_valid <= emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && emit_valid) begin
            r_out_data <= result;
        end
    end

    tle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (item),
        .o_ready      (o_s_axis_tready),
        .o_emit_valid (emit_valid),
        .i_emit_ready (emit_ready),
        .o_result     (result),
        .o_line_we    (line_we),
        .o_line_waddr (line_waddr),
        .o_line_wdata (line_wdata),
        .o_line_raddr (line_raddr),
        .i_line_rdata (line_rdata),
        .o_hist_we    (hist_we),
        .o_hist_waddr (hist_waddr),
        .o_hist_wdata (hist_wdata),
        .o_hist_raddr (hist_raddr),
        .i_hist_rdata (hist_rdata)
    );

    tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::LINE_BYTES)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (line_wdata),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::HIST_WORDS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");
    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_valid && !emit_ready) |=> emit_valid)
        else $error("result dropped while output busy");
endmodule
`default_nettype wire

### hw/rtl/tle_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tle_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/tle_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tle_seq
// Sequencer of the line editor: decodes one item, updates the line and
// history state and runs the byte copies between line and history memories.
// ----------------------------------------------------------------------------
module tle_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  tle_pkg::t_cfg          i_cfg,
    input  wire  tle_pkg::t_item         i_item,
    output logic                         o_ready,
    output logic                         o_emit_valid,
    input  wire                          i_emit_ready,
    output tle_pkg::t_result             o_result,
    // line memory
    output logic                         o_line_we,
    output logic [tle_pkg::CNT_W-1:0]    o_line_waddr,
    output logic [7:0]                   o_line_wdata,
    output logic [tle_pkg::CNT_W-1:0]    o_line_raddr,
    input  wire  [7:0]                   i_line_rdata,
    // history memory
    output logic                         o_hist_we,
    output logic [tle_pkg::HADDR_W-1:0]  o_hist_waddr,
    output logic [7:0]                   o_hist_wdata,
    output logic [tle_pkg::HADDR_W-1:0]  o_hist_raddr,
    input  wire  [7:0]                   i_hist_rdata
);
    localparam int L  = tle_pkg::LINE_BYTES;
    localparam int D  = tle_pkg::HISTORY_DEPTH;
    localparam int CW = tle_pkg::CNT_W;
    localparam int SW = tle_pkg::SLOT_W;
    localparam int FW = tle_pkg::FILL_W;
    localparam int AW = tle_pkg::HADDR_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_COPY = 5'b00100,
        S_PUSH = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]     r_op;
    logic [7:0]     r_byte;
    logic [5:0]     r_idx;
    logic           r_push;

    logic [CW-1:0]  r_count, n_count;
    logic [FW-1:0]  r_fill, n_fill;
    logic [SW-1:0]  r_head, n_head;
    logic [FW-1:0]  r_pos, n_pos;
    logic           r_browse, n_browse;
    logic           r_esc, n_esc;
    logic           r_brk, n_brk;
    logic           r_rdy, n_rdy;
    logic           r_ovf, n_ovf;
    logic [CW-1:0]  r_len [D];

    logic [SW-1:0]  r_slot, n_slot;
    logic [CW-1:0]  r_xlen, n_xlen;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_pend, n_pend;
    logic [CW-1:0]  r_paddr, n_paddr;

    logic           r_ev, n_ev;
    logic [7:0]     r_eb, n_eb;
    logic           r_er, n_er;
    logic [1:0]     r_rd, n_rd;
    logic [7:0]     r_rdat, n_rdat;

    logic           len_we;
    logic [FW-1:0]  load_k;
    logic [SW-1:0]  load_slot;
    logic [SW:0]    slot_sum;
    logic           erase;
    logic           accept;

    assign accept  = (r_state == S_IDLE) && i_item.op_valid;
    assign o_ready = (r_state == S_IDLE);
    assign erase   = (r_byte == tle_pkg::CH_BS) || (r_byte == tle_pkg::CH_DEL);

    // Entry k (newest first) sits in slot head-1-k, modulo the history depth.
    assign slot_sum = (SW+1)'(r_head) + (SW+1)'(D - 1) - (SW+1)'(load_k);
    always_comb begin
        if (slot_sum >= (SW+1)'(D)) begin
            load_slot = SW'(slot_sum - (SW+1)'(D));
        end else begin
            load_slot = SW'(slot_sum);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_fill   = r_fill;
        n_head   = r_head;
        n_pos    = r_pos;
        n_browse = r_browse;
        n_esc    = r_esc;
        n_brk    = r_brk;
        n_rdy    = r_rdy;
        n_ovf    = r_ovf;
        n_slot   = r_slot;
        n_xlen   = r_xlen;
        n_cnt    = r_cnt;
        n_pend   = 1'b0;
        n_paddr  = r_cnt;
        n_ev     = r_ev;
        n_eb     = r_eb;
        n_er     = r_er;
        n_rd     = r_rd;
        n_rdat   = r_rdat;
        len_we   = 1'b0;
        load_k   = '0;

        o_line_we    = 1'b0;
        o_line_waddr = r_count;
        o_line_wdata = r_byte;
        o_line_raddr = r_count - CW'(1);
        o_hist_we    = 1'b0;
        o_hist_waddr = AW'(r_slot) * AW'(L) + AW'(r_paddr);
        o_hist_wdata = i_line_rdata;
        o_hist_raddr = AW'(r_slot) * AW'(L) + AW'(r_cnt);
        o_emit_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item.opcode == tle_pkg::OP_READ) begin
                    o_line_raddr = CW'(i_item.read_index);
                end
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_ev   = 1'b0;
                n_eb   = '0;
                n_er   = 1'b0;
                n_rd   = tle_pkg::RD_NONE;
                n_rdat = '0;
                n_cnt  = '0;
                n_state = S_EMIT;
                case (r_op)
                    tle_pkg::OP_RX: begin
                        if (r_byte == tle_pkg::CH_ESC) begin
                            n_esc = 1'b1;
                        end else if (r_byte == tle_pkg::CH_LBRK && r_esc) begin
                            n_brk = 1'b1;
                        end else if (r_byte == i_cfg.up_code && r_brk) begin
                            n_esc = 1'b0;
                            n_brk = 1'b0;
                            if (!r_rdy && (r_browse ? (r_pos + FW'(1) < r_fill)
                                                    : (r_fill != '0))) begin
                                n_pos    = r_browse ? r_pos + FW'(1) : '0;
                                n_browse = 1'b1;
                                load_k   = n_pos;
                                n_slot   = load_slot;
                                n_xlen   = r_len[load_slot];
                                n_count  = r_len[load_slot];
                                n_rd     = tle_pkg::RD_SHOW;
                                n_state  = S_COPY;
                            end
                        end else if (r_byte == i_cfg.dn_code && r_brk) begin
                            n_esc = 1'b0;
                            n_brk = 1'b0;
                            if (!r_rdy && r_browse) begin
                                if (r_pos != '0) begin
                                    n_pos   = r_pos - FW'(1);
                                    load_k  = n_pos;
                                    n_slot  = load_slot;
                                    n_xlen  = r_len[load_slot];
                                    n_count = r_len[load_slot];
                                    n_rd    = tle_pkg::RD_SHOW;
                                    n_state = S_COPY;
                                end else begin
                                    n_browse = 1'b0;
                                    n_count  = '0;
                                    n_rd     = tle_pkg::RD_CLEAR;
                                end
                            end
                        end else if (r_brk) begin
                            n_esc = 1'b0;
                            n_brk = 1'b0;
                        end else begin
                            n_esc = 1'b0;
                            n_brk = 1'b0;
                            if (i_cfg.echo_en && !(erase && (r_count == '0 || r_rdy))) begin
                                n_ev = 1'b1;
                                n_eb = r_byte;
                            end
                            if (r_rdy) begin
                                n_ovf = 1'b1;
                            end else if (erase) begin
                                if (r_count != '0) begin
                                    n_count = r_count - CW'(1);
                                    n_er    = i_cfg.echo_en;
                                end
                            end else if (r_byte == tle_pkg::CH_CR &&
                                         !(r_count != '0 && i_line_rdata == tle_pkg::CH_BSL)) begin
                                n_rdy    = 1'b1;
                                n_browse = 1'b0;
                            end else if (r_count < CW'(L - 1)) begin
                                o_line_we = 1'b1;
                                n_count   = r_count + CW'(1);
                            end else begin
                                n_rdy    = 1'b1;
                                n_browse = 1'b0;
                            end
                        end
                    end
                    tle_pkg::OP_READ: begin
                        if (CW'(r_idx) < r_count && {2'b00, r_idx} < (CW+2)'(L)) begin
                            n_rdat = i_line_rdata;
                        end
                    end
                    tle_pkg::OP_RELEASE: begin
                        if (r_rdy) begin
                            if (r_push) begin
                                n_slot = r_head;
                                n_xlen = r_count;
                                len_we = 1'b1;
                                n_head = (r_head == SW'(D - 1)) ? '0 : r_head + SW'(1);
                                if (r_fill < FW'(D)) begin
                                    n_fill = r_fill + FW'(1);
                                end
                                n_state = S_PUSH;
                            end
                            n_rdy   = 1'b0;
                            n_ovf   = 1'b0;
                            n_count = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_COPY: begin
                // The history byte addressed in the previous cycle is written to the line now.
                o_line_we    = r_pend;
                o_line_waddr = r_paddr;
                o_line_wdata = i_hist_rdata;
                if (r_cnt < r_xlen) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end else if (!r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_PUSH: begin
                o_line_raddr = r_cnt;
                o_hist_we    = r_pend;
                if (r_cnt < r_xlen) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                end else if (!r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_emit_valid = 1'b1;
                if (i_emit_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.echo_valid  = r_ev;
        o_result.echo_byte   = r_eb;
        o_result.erase_echo  = r_er;
        o_result.redraw      = r_rd;
        o_result.line_ready  = r_rdy;
        o_result.overflow    = r_ovf;
        o_result.line_length = 6'(r_count);
        o_result.read_data   = r_rdat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_fill   <= '0;
            r_head   <= '0;
            r_pos    <= '0;
            r_browse <= 1'b0;
            r_esc    <= 1'b0;
            r_brk    <= 1'b0;
            r_rdy    <= 1'b0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_head   <= n_head;
            r_pos    <= n_pos;
            r_browse <= n_browse;
            r_esc    <= n_esc;
            r_brk    <= n_brk;
            r_rdy    <= n_rdy;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_item.opcode;
            r_byte <= i_item.data_byte;
            r_idx  <= i_item.read_index;
            r_push <= i_item.push_history;
        end
        if (len_we) begin
            r_len[r_head] <= r_count;
        end
        r_slot  <= n_slot;
        r_xlen  <= n_xlen;
        r_cnt   <= n_cnt;
        r_paddr <= n_paddr;
        r_ev    <= n_ev;
        r_eb    <= n_eb;
        r_er    <= n_er;
        r_rd    <= n_rd;
        r_rdat  <= n_rdat;
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(L - 1)) else $error("line count beyond buffer");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(D)) else $error("history fill beyond depth");
    a_browse_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_browse |-> (r_pos < r_fill)) else $error("history position past fill");
    a_ready_no_browse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rdy) |-> !r_browse) else $error("line finished while browsing");
endmodule
`default_nettype wire
